FILE: rtl/core/max_priority_queue_fifo_ties_macros.svh
// assertion macros for the priority queue rtl
// used by the top level only, needs a signal named clock and one named reset
`ifndef MAX_PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH
`define MAX_PRIORITY_QUEUE_FIFO_TIES_MACROS_SVH

// property checked at every rising clock edge outside reset
`define MPQFT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication checked in the cycle after the condition
`define MPQFT_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/core/mpqft_pkg.sv
// shared constants, codes and types of the priority queue
// no dependencies
package mpqft_pkg;

   localparam int CAPACITY    = 128;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int VAL_W       = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef struct packed {
      logic                    push;
      logic                    pop;
      logic signed [VAL_W-1:0] value;
   } cell_ctl_type;

endpackage

FILE: rtl/core/mpqft_req_if.sv
// request channel of the priority queue: valid, ready and payload
// depends on mpqft_pkg
interface mpqft_req_if import mpqft_pkg::*;;

   logic                    valid;
   logic                    ready;
   logic                    mode;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);

endinterface

FILE: rtl/core/mpqft_rsp_if.sv
// response channel of the priority queue: valid, ready and payload
// depends on mpqft_pkg
interface mpqft_rsp_if import mpqft_pkg::*;;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic signed [VAL_W-1:0] removed_value;
   logic signed [VAL_W-1:0] top_value;
   logic                    top_valid;
   logic [COUNT_OUT_W-1:0]  entry_count;

   modport source (output valid, output status, output removed_value, output top_value,
                   output top_valid, output entry_count, input ready);
   modport sink   (input valid, input status, input removed_value, input top_value,
                   input top_valid, input entry_count, output ready);

endinterface

FILE: rtl/core/mpqft_cell.sv
// one cell of the sorted chain: holds one value, compares it with a push
// depends on mpqft_pkg
module mpqft_cell import mpqft_pkg::*; (
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  logic                    occupied,
   input  logic signed [VAL_W-1:0] prev_value,
   input  logic                    prev_greater,
   input  logic signed [VAL_W-1:0] next_value,
   output logic signed [VAL_W-1:0] value_out,
   output logic                    greater_out
);

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   // strict compare keeps equal values in arrival order
   assign greater_out = !occupied || (ctl.value > value_ff);
   assign value_out   = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.push && greater_out) begin
         value_in = prev_greater ? prev_value : ctl.value;
      end else if (ctl.pop) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

FILE: rtl/core/mpqft_chain.sv
// row of cells kept in descending order, head holds the top value
// depends on mpqft_pkg and mpqft_cell
module mpqft_chain import mpqft_pkg::*; (
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  logic [CNT_W-1:0]        count,
   output logic signed [VAL_W-1:0] top_value
);

   logic signed [VAL_W-1:0] values  [CAPACITY];
   logic                    greater [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VAL_W-1:0] prev_v;
      logic                    prev_g;
      logic signed [VAL_W-1:0] next_v;
      logic                    occ;

      assign occ = CNT_W'(i) < count;

      if (i == 0) begin : g_head
         assign prev_v = '0;
         assign prev_g = 1'b0;
      end else begin : g_body
         assign prev_v = values[i-1];
         assign prev_g = greater[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_v = values[i];
      end else begin : g_inner
         assign next_v = values[i+1];
      end

      mpqft_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .occupied     (occ),
         .prev_value   (prev_v),
         .prev_greater (prev_g),
         .next_value   (next_v),
         .value_out    (values[i]),
         .greater_out  (greater[i])
      );
   end

   assign top_value = values[0];

endmodule

FILE: rtl/core/max_priority_queue_fifo_ties.sv
// top level of the bounded max priority queue with first-in order among ties
// depends on mpqft_pkg, mpqft_req_if, mpqft_rsp_if, mpqft_chain and the macro header
//
//   channel  dir  payload                                          accepted when
//   req_ch   in   mode, value                                      valid && ready
//   rsp_ch   out  status, removed_value, top_value, top_valid,     valid && ready
//                 entry_count
//
// a request updates every cell of the chain in the cycle it is accepted; its
// response is held pending, then registered once rsp_ch is free: one request
// per cycle unless rsp_ch stalls. the parallel compare in every cell sets the
// cycle; no sweep after reset. reset empties the queue and drops any response
// in flight. a pending response waiting on rsp_ch.ready holds req_ch.ready low.
`include "max_priority_queue_fifo_ties_macros.svh"

module max_priority_queue_fifo_ties import mpqft_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   mpqft_req_if.sink          req_ch,
   mpqft_rsp_if.source        rsp_ch
);

   logic                    accept;
   logic                    is_pop;
   logic                    full;
   logic                    empty;
   logic                    rsp_free;
   logic                    move;
   cell_ctl_type            ctl;
   logic signed [VAL_W-1:0] chain_top;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    pend_ff, pend_in;
   status_type              pend_status_ff, pend_status_in;
   logic signed [VAL_W-1:0] pend_removed_ff, pend_removed_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff;
   logic signed [VAL_W-1:0] rsp_removed_ff;
   logic signed [VAL_W-1:0] rsp_top_ff;
   logic                    rsp_top_valid_ff;
   logic [COUNT_OUT_W-1:0]  rsp_count_ff;

   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign move         = pend_ff && rsp_free;
   assign req_ch.ready = !reset && (!pend_ff || rsp_free);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_pop       = req_ch.mode == MODE_POP;
   assign full         = count_ff == CNT_W'(CAPACITY);
   assign empty        = count_ff == '0;

   assign ctl.push  = accept && !is_pop && !full;
   assign ctl.pop   = accept && is_pop && !empty;
   assign ctl.value = req_ch.value;

   mpqft_chain u_chain (
      .clock     (clock),
      .ctl       (ctl),
      .count     (count_ff),
      .top_value (chain_top)
   );

   always_comb begin
      count_in        = count_ff;
      pend_in         = pend_ff;
      pend_status_in  = pend_status_ff;
      pend_removed_in = pend_removed_ff;
      rsp_valid_in    = rsp_valid_ff;

      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         pend_in         = 1'b1;
         pend_status_in  = ST_OK;
         pend_removed_in = '0;
         if (is_pop) begin
            if (empty) begin
               pend_status_in = ST_EMPTY;
            end else begin
               pend_removed_in = chain_top;
            end
         end else if (full) begin
            pend_status_in = ST_FULL;
         end
      end else if (move) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, the chain already holds the state after the pending request
   always_ff @(posedge clock) begin
      pend_status_ff  <= pend_status_in;
      pend_removed_ff <= pend_removed_in;
      if (move) begin
         rsp_status_ff    <= pend_status_ff;
         rsp_removed_ff   <= pend_removed_ff;
         rsp_top_valid_ff <= !empty;
         rsp_top_ff       <= empty ? '0 : chain_top;
         rsp_count_ff     <= COUNT_OUT_W'(count_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.removed_value = rsp_removed_ff;
   assign rsp_ch.top_value     = rsp_top_ff;
   assign rsp_ch.top_valid     = rsp_top_valid_ff;
   assign rsp_ch.entry_count   = rsp_count_ff;

   `MPQFT_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `MPQFT_ASSERT_NEXT(a_push_count, ctl.push, count_ff == $past(count_ff) + CNT_W'(1),
      "push did not grow count")
   `MPQFT_ASSERT_NEXT(a_pop_count, ctl.pop, count_ff == $past(count_ff) - CNT_W'(1),
      "pop did not shrink count")
   `MPQFT_ASSERT_NEXT(a_pend_moves, move, rsp_valid_ff && !($past(accept) == 1'b0 && pend_ff),
      "pending response lost")
   `MPQFT_ASSERT(a_top_zero, !rsp_valid_ff || rsp_top_valid_ff || rsp_top_ff == '0,
      "top value not zero on empty queue")

endmodule
